// ===== src/c2p_pkg.sv =====
`timescale 1ns / 1ps

package c2p_pkg;

   localparam int GUARD_BITS   = 16;
   localparam int Z_WIDTH      = 35;
   localparam int PHASE_SHIFT  = 17;
   localparam int PHASE_LIMIT  = 25736;
   localparam int OUT_WIDTH    = 16;
   localparam int MAG_MAX      = 65535;
   localparam int ATAN_ENTRIES = 32;

   // Q2.30 radians
   localparam logic signed [Z_WIDTH-1:0] PI_Q30     = 35'sd3373259426;
   localparam logic signed [Z_WIDTH-1:0] ROUND_HALF = 35'sd65536;

   localparam logic signed [Z_WIDTH-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
      35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
      35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
      35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
      35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
      35'sd1023,      35'sd511,       35'sd255,       35'sd127,
      35'sd63,        35'sd31,        35'sd15,        35'sd7,
      35'sd3,         35'sd1,         35'sd0,         35'sd0
   };

endpackage

// ===== src/c2p_sqrt.sv =====
`timescale 1ns / 1ps

module c2p_sqrt #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int STAGES       = 18
) (
   input  logic                                  clock,
   input  logic signed [SAMPLE_WIDTH-1:0]        re,
   input  logic signed [SAMPLE_WIDTH-1:0]        im,
   output logic        [c2p_pkg::OUT_WIDTH-1:0]  magnitude
);

   localparam int PW    = 2 * SAMPLE_WIDTH;
   localparam int STEPS = SAMPLE_WIDTH;

   logic signed [PW-1:0] re_w;
   logic signed [PW-1:0] im_w;
   logic        [PW-1:0] sq_re_ff;
   logic        [PW-1:0] sq_im_ff;
   // element j holds the state after pipeline stage j+1
   logic        [PW-1:0] rem_ff  [STAGES-1];
   logic        [PW-1:0] root_ff [STAGES-1];
   logic        [PW-1:0] root_rnd;

   assign re_w = PW'(re);
   assign im_w = PW'(im);

   // stage 0: squares
   always_ff @(posedge clock) begin
      sq_re_ff <= $unsigned(re_w * re_w);
      sq_im_ff <= $unsigned(im_w * im_w);
   end

   genvar j;
   generate
      for (j = 0; j < STAGES - 1; j++) begin : g_stage
         if (j == 0) begin : g_sum
            always_ff @(posedge clock) begin
               rem_ff[j]  <= sq_re_ff + sq_im_ff;
               root_ff[j] <= '0;
            end
         end else if (j <= STEPS) begin : g_step
            localparam int T = j - 1;
            localparam logic [PW-1:0] BIT = PW'(1) << (PW - 2 - 2 * T);
            logic [PW:0]   trial;
            logic [PW-1:0] rem_in;
            logic [PW-1:0] root_in;

            assign trial = {1'b0, root_ff[j-1]} + {1'b0, BIT};

            always_comb begin
               if ({1'b0, rem_ff[j-1]} >= trial) begin
                  rem_in  = rem_ff[j-1] - trial[PW-1:0];
                  root_in = (root_ff[j-1] >> 1) + BIT;
               end else begin
                  rem_in  = rem_ff[j-1];
                  root_in = root_ff[j-1] >> 1;
               end
            end

            always_ff @(posedge clock) begin
               rem_ff[j]  <= rem_in;
               root_ff[j] <= root_in;
            end
         end else begin : g_pass
            always_ff @(posedge clock) begin
               rem_ff[j]  <= rem_ff[j-1];
               root_ff[j] <= root_ff[j-1];
            end
         end
      end
   endgenerate

   // round to nearest: remainder above root means the half point was passed
   assign root_rnd = (rem_ff[STAGES-2] > root_ff[STAGES-2]) ? root_ff[STAGES-2] + PW'(1)
                                                             : root_ff[STAGES-2];

   assign magnitude = (root_rnd > PW'(c2p_pkg::MAG_MAX)) ? c2p_pkg::OUT_WIDTH'(c2p_pkg::MAG_MAX)
                                                         : root_rnd[c2p_pkg::OUT_WIDTH-1:0];

endmodule

// ===== src/c2p_cordic.sv =====
`timescale 1ns / 1ps

module c2p_cordic #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ROTATION_STAGES = 16,
   parameter int STAGES          = 18
) (
   input  logic                                        clock,
   input  logic signed [SAMPLE_WIDTH-1:0]              re,
   input  logic signed [SAMPLE_WIDTH-1:0]              im,
   output logic signed [c2p_pkg::OUT_WIDTH-1:0]        phase_angle
);

   localparam int XW  = SAMPLE_WIDTH + c2p_pkg::GUARD_BITS + 3;
   localparam int ZW  = c2p_pkg::Z_WIDTH;
   localparam int PHW = ZW - c2p_pkg::PHASE_SHIFT;
   localparam logic signed [PHW-1:0] PH_MAX = PHW'(c2p_pkg::PHASE_LIMIT);
   localparam logic signed [PHW-1:0] PH_MIN = -PH_MAX;

   logic signed [XW-1:0] x_ff    [STAGES];
   logic signed [XW-1:0] y_ff    [STAGES];
   logic signed [ZW-1:0] z_ff    [STAGES];
   logic                 zero_ff [STAGES];

   logic signed [ZW-1:0]  z_rnd;
   logic signed [PHW-1:0] ph_raw;
   logic signed [PHW-1:0] ph_clip;

   genvar k;
   generate
      for (k = 0; k < STAGES; k++) begin : g_stage
         if (k == 0) begin : g_prep
            logic signed [XW-1:0] re_x;
            logic signed [XW-1:0] im_x;
            logic                 re_neg;

            assign re_x   = XW'(re);
            assign im_x   = XW'(im);
            assign re_neg = re[SAMPLE_WIDTH-1];

            // left half-plane: rotate by pi up front
            always_ff @(posedge clock) begin
               x_ff[k]    <= (re_neg ? -re_x : re_x) <<< c2p_pkg::GUARD_BITS;
               y_ff[k]    <= (re_neg ? -im_x : im_x) <<< c2p_pkg::GUARD_BITS;
               z_ff[k]    <= !re_neg ? '0
                           : (im[SAMPLE_WIDTH-1] ? -c2p_pkg::PI_Q30 : c2p_pkg::PI_Q30);
               zero_ff[k] <= (re == '0);
            end
         end else if (k <= ROTATION_STAGES) begin : g_rot
            localparam int I = k - 1;
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic signed [XW-1:0] x_in;
            logic signed [XW-1:0] y_in;
            logic signed [ZW-1:0] z_in;

            assign dx = y_ff[k-1] >>> I;
            assign dy = x_ff[k-1] >>> I;

            always_comb begin
               if (!y_ff[k-1][XW-1]) begin
                  x_in = x_ff[k-1] + dx;
                  y_in = y_ff[k-1] - dy;
                  z_in = z_ff[k-1] + c2p_pkg::ATAN_Q30[I];
               end else begin
                  x_in = x_ff[k-1] - dx;
                  y_in = y_ff[k-1] + dy;
                  z_in = z_ff[k-1] - c2p_pkg::ATAN_Q30[I];
               end
            end

            always_ff @(posedge clock) begin
               x_ff[k]    <= x_in;
               y_ff[k]    <= y_in;
               z_ff[k]    <= z_in;
               zero_ff[k] <= zero_ff[k-1];
            end
         end else begin : g_pass
            always_ff @(posedge clock) begin
               x_ff[k]    <= x_ff[k-1];
               y_ff[k]    <= y_ff[k-1];
               z_ff[k]    <= z_ff[k-1];
               zero_ff[k] <= zero_ff[k-1];
            end
         end
      end
   endgenerate

   // Q2.30 -> Q3.13, round half up
   assign z_rnd  = z_ff[STAGES-1] + c2p_pkg::ROUND_HALF;
   assign ph_raw = z_rnd[ZW-1:c2p_pkg::PHASE_SHIFT];

   always_comb begin
      if (ph_raw > PH_MAX) begin
         ph_clip = PH_MAX;
      end else if (ph_raw < PH_MIN) begin
         ph_clip = PH_MIN;
      end else begin
         ph_clip = ph_raw;
      end
   end

   assign phase_angle = zero_ff[STAGES-1] ? '0 : ph_clip[c2p_pkg::OUT_WIDTH-1:0];

endmodule

// ===== src/cartesian_to_polar_core.sv =====
`timescale 1ns / 1ps

// Cartesian to polar conversion, one complex sample per item.
// Input: req_real_part / req_imag_part are taken at a rising edge with start
// high and busy low. busy is never raised, so an item may enter every cycle.
// Output: rsp_valid strobes for one cycle with rsp_magnitude (rounded
// sqrt(re^2+im^2), saturated at 65535) and rsp_phase_angle (atan2(im, re),
// radians Q3.13, clamped to +/-25736, zero whenever the real part is zero).
// Pipeline: the inputs are registered, then each unit runs through STAGES
// registers, with STAGES = max(SAMPLE_WIDTH + 2, ROTATION_STAGES + 1), and
// the outputs are registered again. The square root (one digit per stage
// after squaring and summing) and the CORDIC (one micro-rotation per stage
// after the quadrant fold) run side by side; the longer one sets the depth.
// Throughput: one item per cycle.
// Reset clears every valid bit; items in flight are dropped.
// The receiver cannot stall: each result is on the ports for one cycle only
// and must be taken then.
module cartesian_to_polar_core #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_imag_part,
   output logic                                     rsp_valid,
   output logic        [c2p_pkg::OUT_WIDTH-1:0]     rsp_magnitude,
   output logic signed [c2p_pkg::OUT_WIDTH-1:0]     rsp_phase_angle
);

   localparam int STAGES = (SAMPLE_WIDTH + 2 > ROTATION_STAGES + 1) ? SAMPLE_WIDTH + 2
                                                                    : ROTATION_STAGES + 1;

   logic                                 accept;
   logic [STAGES:0]                      vld_ff;
   logic [STAGES:0]                      vld_in;
   logic                                 rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0]       re_ff;
   logic signed [SAMPLE_WIDTH-1:0]       im_ff;
   logic        [c2p_pkg::OUT_WIDTH-1:0] mag_in;
   logic signed [c2p_pkg::OUT_WIDTH-1:0] phase_in;
   logic        [c2p_pkg::OUT_WIDTH-1:0] mag_ff;
   logic signed [c2p_pkg::OUT_WIDTH-1:0] phase_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[STAGES-1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      re_ff    <= req_real_part;
      im_ff    <= req_imag_part;
      mag_ff   <= mag_in;
      phase_ff <= phase_in;
   end

   c2p_sqrt #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STAGES       (STAGES)
   ) u_sqrt (
      .clock     (clock),
      .re        (re_ff),
      .im        (im_ff),
      .magnitude (mag_in)
   );

   c2p_cordic #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .ROTATION_STAGES (ROTATION_STAGES),
      .STAGES          (STAGES)
   ) u_cordic (
      .clock       (clock),
      .re          (re_ff),
      .im          (im_ff),
      .phase_angle (phase_in)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_magnitude   = mag_ff;
   assign rsp_phase_angle = phase_ff;

`ifndef ASSERT_OFF
   localparam int LAT = STAGES + 2;
   localparam logic signed [c2p_pkg::OUT_WIDTH-1:0] PH_LIM =
      c2p_pkg::OUT_WIDTH'(c2p_pkg::PHASE_LIMIT);

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without an item accepted LAT cycles earlier");

   a_phase_needs_mag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase_angle != '0) |-> (rsp_magnitude != '0))
      else $error("nonzero phase with zero magnitude");

   a_phase_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase_angle <= PH_LIM) && (rsp_phase_angle >= -PH_LIM))
      else $error("phase outside clamp range");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int W          = 16;
   localparam int OW         = c2p_pkg::OUT_WIDTH;
   localparam int N_RANDOM   = 1300;
   localparam int CYCLE_CAP  = 300000;
   localparam int DRAIN_WAIT = 40;
   localparam int IDLE_PCT   = 27;

   localparam int     CORDIC_STEPS = 16;
   localparam longint PI_Z         = 64'sd3373259426;   // Q2.30
   localparam int     Z_ROUND      = 65536;
   localparam int     Z_SHIFT      = 17;
   localparam int     ANGLE_CLAMP  = 25736;
   localparam longint MAG_CEIL     = 65535;

   localparam longint ARCTAN [CORDIC_STEPS] = '{
      843314856, 497837829, 263043836, 133525158,
      67021686,  33543515,  16775850,  8388437,
      4194282,   2097149,   1048575,   524287,
      262143,    131071,    65535,     32767
   };

   typedef struct packed {
      logic        [OW-1:0] mag;
      logic signed [OW-1:0] phase;
   } polar_type;

   typedef struct packed {
      logic signed [W-1:0]  re;
      logic signed [W-1:0]  im;
      logic                 typed_in;
      logic        [OW-1:0] mag;
      logic signed [OW-1:0] phase;
   } vector_row_type;

   localparam int N_DIRECTED = 22;

   // typed_in rows carry the answer; the rest go through to_polar
   localparam vector_row_type DIRECTED [N_DIRECTED] = '{
      '{16'sd0,      16'sd0,      1'b1, 16'd0,     16'sd0},
      '{16'sd0,      16'sd32767,  1'b1, 16'd32767, 16'sd0},
      '{16'sd0,      -16'sd32768, 1'b1, 16'd32768, 16'sd0},
      '{16'sd0,      16'sd1,      1'b1, 16'd1,     16'sd0},
      '{16'sd0,      -16'sd1,     1'b1, 16'd1,     16'sd0},
      '{16'sd32767,  16'sd0,      1'b0, 16'd0,     16'sd0},
      '{-16'sd32768, 16'sd0,      1'b0, 16'd0,     16'sd0},
      '{-16'sd32768, -16'sd1,     1'b0, 16'd0,     16'sd0},
      '{-16'sd32768, 16'sd1,      1'b0, 16'd0,     16'sd0},
      '{-16'sd32768, -16'sd32768, 1'b0, 16'd0,     16'sd0},
      '{-16'sd32768, 16'sd32767,  1'b0, 16'd0,     16'sd0},
      '{16'sd32767,  16'sd32767,  1'b0, 16'd0,     16'sd0},
      '{16'sd32767,  -16'sd32768, 1'b0, 16'd0,     16'sd0},
      '{16'sd1,      16'sd0,      1'b0, 16'd0,     16'sd0},
      '{-16'sd1,     16'sd0,      1'b0, 16'd0,     16'sd0},
      '{16'sd1,      16'sd1,      1'b0, 16'd0,     16'sd0},
      '{-16'sd1,     -16'sd1,     1'b0, 16'd0,     16'sd0},
      '{-16'sd1,     16'sd1,      1'b0, 16'd0,     16'sd0},
      '{16'sd3,      16'sd4,      1'b0, 16'd0,     16'sd0},
      '{16'sd100,    -16'sd100,   1'b0, 16'd0,     16'sd0},
      '{-16'sd5000,  -16'sd2,     1'b0, 16'd0,     16'sd0},
      '{16'sd21845,  -16'sd10923, 1'b0, 16'd0,     16'sd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [W-1:0]  req_real_part = '0;
   logic signed [W-1:0]  req_imag_part = '0;
   logic                 rsp_valid;
   logic        [OW-1:0] rsp_magnitude;
   logic signed [OW-1:0] rsp_phase_angle;

   polar_type next_polar = '0;
   polar_type polar_fifo[$];
   int        mismatch_count = 0;
   int        cycle_count = 0;

   cartesian_to_polar_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_real_part   (req_real_part),
      .req_imag_part   (req_imag_part),
      .rsp_valid       (rsp_valid),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_phase_angle (rsp_phase_angle)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // rounded sqrt by digit recurrence, phase by vectoring CORDIC
   function automatic polar_type to_polar(logic signed [W-1:0] re_in,
                                          logic signed [W-1:0] im_in);
      longint re, im, are, aim, rem, root, bit_w, x, y, z, dx, dy, ang;
      int i;
      polar_type res;
      re = re_in;
      im = im_in;
      are = (re < 0) ? -re : re;
      aim = (im < 0) ? -im : im;
      rem = are * are + aim * aim;
      root = 0;
      bit_w = 64'sd1 <<< 62;
      while (bit_w > rem) bit_w = bit_w >>> 2;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem = rem - (root + bit_w);
            root = (root >>> 1) + bit_w;
         end else begin
            root = root >>> 1;
         end
         bit_w = bit_w >>> 2;
      end
      if (rem > root) root = root + 1;
      if (root > MAG_CEIL) root = MAG_CEIL;
      ang = 0;
      if (re != 0) begin
         x = are <<< 16;
         y = ((re < 0) ? -im : im) <<< 16;
         z = 0;
         if (re < 0) z = (im >= 0) ? PI_Z : -PI_Z;
         for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + ARCTAN[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - ARCTAN[i];
            end
         end
         ang = (z + Z_ROUND) >>> Z_SHIFT;
         if (ang > ANGLE_CLAMP) ang = ANGLE_CLAMP;
         if (ang < -ANGLE_CLAMP) ang = -ANGLE_CLAMP;
      end
      res.mag = root[OW-1:0];
      res.phase = ang[OW-1:0];
      return res;
   endfunction

   function automatic logic signed [W-1:0] corner_value();
      case ($urandom_range(5))
         0: return -16'sd32768;
         1: return -16'sd32767;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   task automatic send_sample(input logic signed [W-1:0] re, input logic signed [W-1:0] im,
                              input polar_type want, input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      next_polar <= want;
      do @(posedge clock); while (busy);
   endtask

   // checker and scoreboard push; both sample pre-edge values
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("%0t: timeout", $time);
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (polar_fifo.size() == 0) begin
            $display("%0t: unexpected item, mag %0d phase %0d", $time,
                     rsp_magnitude, rsp_phase_angle);
            mismatch_count <= mismatch_count + 1;
         end else begin
            if (rsp_magnitude !== polar_fifo[0].mag ||
                rsp_phase_angle !== polar_fifo[0].phase) begin
               if (rsp_magnitude !== polar_fifo[0].mag)
                  $display("%0t: magnitude expected %0d actual %0d", $time,
                           polar_fifo[0].mag, rsp_magnitude);
               if (rsp_phase_angle !== polar_fifo[0].phase)
                  $display("%0t: phase expected %0d actual %0d", $time,
                           polar_fifo[0].phase, rsp_phase_angle);
               mismatch_count <= mismatch_count + 1;
            end
            void'(polar_fifo.pop_front());
         end
      end
      if (!reset && start && !busy) polar_fifo.push_back(next_polar);
   end

   initial begin
      int k, mode;
      logic signed [W-1:0] re, im;
      polar_type want;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < N_DIRECTED; k++) begin
         if (DIRECTED[k].typed_in) begin
            want.mag = DIRECTED[k].mag;
            want.phase = DIRECTED[k].phase;
         end else begin
            want = to_polar(DIRECTED[k].re, DIRECTED[k].im);
         end
         send_sample(DIRECTED[k].re, DIRECTED[k].im, want, 1'b1);
      end

      for (k = 0; k < N_RANDOM; k++) begin
         mode = $urandom_range(99);
         re = W'($urandom);
         im = W'($urandom);
         if (mode < 40) begin
            // full range as drawn
         end else if (mode < 60) begin
            re = W'(int'($urandom_range(511)) - 256);
            im = W'(int'($urandom_range(511)) - 256);
         end else if (mode < 68) begin
            re = '0;
         end else if (mode < 76) begin
            im = '0;
         end else if (mode < 84) begin
            re = corner_value();
            im = corner_value();
         end else if (mode < 92) begin
            // negative real axis: phase sits near +/-pi and the clamp
            re = -W'($urandom_range(32768, 1));
            im = W'(int'($urandom_range(6)) - 3);
         end else begin
            im = ($urandom_range(1) == 1) ? re : -re;
         end
         // middle stretch runs back to back
         send_sample(re, im, to_polar(re, im), (k < 400 || k >= 700));
      end
      start <= 1'b0;

      while (polar_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
